// ----- src/double_click_actuator_sequencer_macros.svh -----
// Assertion macros for the double-click actuator sequencer
`ifndef DOUBLE_CLICK_ACTUATOR_SEQUENCER_MACROS_SVH
`define DOUBLE_CLICK_ACTUATOR_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define DCAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DCAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/dcas_pkg.sv -----
// Shared types and constants of the double-click actuator sequencer
package dcas_pkg;

	localparam int unsigned TimeW = 16;
	localparam int unsigned CntW  = 2;

	localparam logic [TimeW-1:0] TIME_SAT = '1;

	localparam logic [TimeW-1:0] RUN_LIMIT_RST = 16'd15000;
	localparam logic [TimeW-1:0] CLICK_GAP_RST = 16'd2000;
	localparam logic [TimeW-1:0] DEBOUNCE_RST  = 16'd200;

	localparam logic [1:0] REG_RUN_LIMIT = 2'd0;
	localparam logic [1:0] REG_CLICK_GAP = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE  = 2'd2;

	localparam logic [CntW-1:0] CNT_START = 2'd2;
	localparam logic [CntW-1:0] CNT_STOP  = 2'd3;

	typedef struct packed {
		logic [TimeW-1:0] run_limit;
		logic [TimeW-1:0] click_gap;
		logic [TimeW-1:0] debounce;
	} cfg_t;

	typedef struct packed {
		logic open_press;
		logic close_press;
	} press_t;

	function automatic logic [TimeW-1:0] inc_sat(input logic [TimeW-1:0] v);
		return (v == TIME_SAT) ? v : v + 16'd1;
	endfunction

endpackage

// ----- src/dcas_if.sv -----
// Handshake channels: button tick in, actuator status out
interface dcas_tick_if;
	logic valid;
	logic ready;
	logic open_level;
	logic close_level;

	modport source (output valid, output open_level, output close_level, input ready);
	modport sink   (input valid, input open_level, input close_level, output ready);
endinterface

interface dcas_result_if;
	logic       valid;
	logic       ready;
	logic       open_drive;
	logic       close_drive;
	logic       in_motion;
	logic [1:0] open_count;
	logic [1:0] close_count;

	modport source (output valid, output open_drive, output close_drive, output in_motion,
		output open_count, output close_count, input ready);
	modport sink   (input valid, input open_drive, input close_drive, input in_motion,
		input open_count, input close_count, output ready);
endinterface

// ----- src/dcas_button.sv -----
// Debouncer and press detector for one button
module dcas_button (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      level,
	input  logic [dcas_pkg::TimeW-1:0] debounce,
	output logic                      press
);
	import dcas_pkg::*;

	logic             prev_q;
	logic [TimeW-1:0] since_q;
	logic [TimeW-1:0] since_inc;
	logic             change;

	assign since_inc = inc_sat(since_q);
	assign change    = level != prev_q;
	assign press     = change && level && (since_inc > debounce);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			since_q <= '0;
		end else if (step) begin
			prev_q  <= level;
			// any change restarts the quiet time
			since_q <= change ? '0 : since_inc;
		end
	end
endmodule

// ----- src/dcas_core.sv -----
// Click counting, drive and run-time state of the sequencer
module dcas_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  dcas_pkg::press_t          press,
	input  dcas_pkg::cfg_t            cfg,
	output logic                      open_drive,
	output logic                      close_drive,
	output logic                      in_motion,
	output logic [dcas_pkg::CntW-1:0] open_count,
	output logic [dcas_pkg::CntW-1:0] close_count
);
	import dcas_pkg::*;

	logic [CntW-1:0]  open_clicks_q, close_clicks_q;
	logic [TimeW-1:0] open_since_press_q, close_since_press_q, run_elapsed_q;
	logic             moving_q, open_out_q, close_out_q;

	logic [CntW-1:0]  oc, cc;
	logic [TimeW-1:0] osp, csp, re;
	logic             mv, oo, co;

	always_comb begin
		osp = inc_sat(open_since_press_q);
		csp = inc_sat(close_since_press_q);
		re  = inc_sat(run_elapsed_q);
		oc  = open_clicks_q;
		cc  = close_clicks_q;
		mv  = moving_q;
		oo  = open_out_q;
		co  = close_out_q;

		if (press.open_press) begin
			oc = oc + 2'd1;
			cc = '0;
			co = 1'b0;
			if (oc == CNT_START) begin
				oo = 1'b1;
				re = '0;
				mv = 1'b1;
			end else if (oc == CNT_STOP) begin
				oc = '0;
				oo = 1'b0;
				mv = 1'b0;
			end
			osp = '0;
		end
		// close press is served after the open press of the same tick
		if (press.close_press) begin
			cc = cc + 2'd1;
			oc = '0;
			oo = 1'b0;
			if (cc == CNT_START) begin
				co = 1'b1;
				re = '0;
				mv = 1'b1;
			end else if (cc == CNT_STOP) begin
				cc = '0;
				co = 1'b0;
				mv = 1'b0;
			end
			csp = '0;
		end

		if (mv && (re > cfg.run_limit)) begin
			oo = 1'b0;
			co = 1'b0;
			oc = '0;
			cc = '0;
			mv = 1'b0;
		end
		if (!mv && (osp > cfg.click_gap))
			oc = '0;
		if (!mv && (csp > cfg.click_gap))
			cc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_clicks_q       <= '0;
			close_clicks_q      <= '0;
			open_since_press_q  <= '0;
			close_since_press_q <= '0;
			run_elapsed_q       <= '0;
			moving_q            <= 1'b0;
			open_out_q          <= 1'b0;
			close_out_q         <= 1'b0;
		end else if (step) begin
			open_clicks_q       <= oc;
			close_clicks_q      <= cc;
			open_since_press_q  <= osp;
			close_since_press_q <= csp;
			run_elapsed_q       <= re;
			moving_q            <= mv;
			open_out_q          <= oo;
			close_out_q         <= co;
		end
	end

	// state after the tick is the result
	assign open_drive  = open_out_q;
	assign close_drive = close_out_q;
	assign in_motion   = moving_q;
	assign open_count  = open_clicks_q;
	assign close_count = close_clicks_q;
endmodule

// ----- src/double_click_actuator_sequencer.sv -----
// Double-click actuator sequencer: top level
// Path: an accepted tick goes to the input register, then to the result register.
// Throughput: one tick per cycle while result.ready is high; the result register frees
// as it is taken, so the input register and state update advance in the same cycle.
// Reset: arst_n clears all state but the held levels, empties both registers and loads
// the default run limit, click gap and debounce time. No clearing pass.
module double_click_actuator_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [dcas_pkg::TimeW-1:0] cfg_wdata,
	dcas_tick_if.sink                  tick,
	dcas_result_if.source              result
);
	import dcas_pkg::*;

	`include "double_click_actuator_sequencer_macros.svh"

	cfg_t   cfg_q;
	logic   vld_s1, open_lvl_s1, close_lvl_s1;
	logic   out_vld_q;
	logic   advance;
	logic   open_press, close_press;
	press_t press;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_limit <= RUN_LIMIT_RST;
			cfg_q.click_gap <= CLICK_GAP_RST;
			cfg_q.debounce  <= DEBOUNCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RUN_LIMIT: cfg_q.run_limit <= cfg_wdata;
				REG_CLICK_GAP: cfg_q.click_gap <= cfg_wdata;
				REG_DEBOUNCE:  cfg_q.debounce  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance the held tick whenever the result slot is free or being emptied
	assign advance    = vld_s1 && (!out_vld_q || result.ready);
	assign tick.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (tick.ready)
				vld_s1 <= tick.valid;
			if (advance)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			open_lvl_s1  <= tick.open_level;
			close_lvl_s1 <= tick.close_level;
		end
	end

	dcas_button u_open_btn (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.level    (open_lvl_s1),
		.debounce (cfg_q.debounce),
		.press    (open_press)
	);

	dcas_button u_close_btn (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.level    (close_lvl_s1),
		.debounce (cfg_q.debounce),
		.press    (close_press)
	);

	assign press = {open_press, close_press};

	dcas_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.press       (press),
		.cfg         (cfg_q),
		.open_drive  (result.open_drive),
		.close_drive (result.close_drive),
		.in_motion   (result.in_motion),
		.open_count  (result.open_count),
		.close_count (result.close_count)
	);

	assign result.valid = out_vld_q;

	`DCAS_ASSERT_NOW(a_one_direction, result.valid,
		!(result.open_drive && result.close_drive), "both drives active")
	`DCAS_ASSERT_NOW(a_drive_moving, result.open_drive || result.close_drive,
		result.in_motion, "drive without motion")
	`DCAS_ASSERT_NOW(a_count_range, 1'b1,
		(result.open_count != CNT_STOP) && (result.close_count != CNT_STOP),
		"click count out of range")
	`DCAS_ASSERT_NEXT(a_tick_held, tick.valid && tick.ready, vld_s1, "accepted tick lost")
endmodule
